@@ hw/rtl/gpt_pkg.sv @@
`default_nettype none
package gpt_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_MEAN  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD_SIGMA = 8'd1;

  // Reset values of the configuration registers.
  localparam logic signed [31:0] MEAN_RESET  = 32'sd0;
  localparam logic [31:0]        SIGMA_RESET = 32'd65536;

  // 2*ln(2) in Q1.27, truncated.
  localparam logic [27:0] LN2X2_Q27 = 28'hB17217F;

  // Queue between the front and the back part.
  localparam int QUEUE_DEPTH  = 8;
  localparam int QUEUE_PTR_W  = 3;
  localparam int FRONT_STAGES = 3;

  // Input word: one pair of uniform draws.
  typedef struct packed {
    logic [31:0] uniform_a;
    logic [31:0] uniform_b;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic signed [31:0] unit_normal;
    logic signed [31:0] scaled_sample;
  } out_word_t;

  // Accepted pair inside the unit circle: x1 squared and w, both scaled by 2^62.
  typedef struct packed {
    logic        neg;
    logic [61:0] sq1;
    logic [61:0] w;
  } pair_t;

  // z squared with scale 2^30, and the sign of z.
  typedef struct packed {
    logic        neg;
    logic [37:0] t;
  } zsq_t;

endpackage
`default_nettype wire

@@ hw/rtl/gpt_front.sv @@
`default_nettype none
module gpt_front import gpt_pkg::*; #(
  parameter int UNIFORM_BITS = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     take,
  input  wire in_word_t word,
  output logic          push_valid,
  output pair_t         push_word
);

  localparam int EFF_BITS = (UNIFORM_BITS >= 32) ? 32 : UNIFORM_BITS;
  localparam int SHIFT    = 32 - EFF_BITS;

  logic [31:0] ua, ub;
  logic [31:0] a1_nxt, a2_nxt;
  logic        v1_r, v2_r, push_valid_r;
  logic        neg1_r, neg2_r;
  logic [31:0] a1_r, a2_r;
  logic [63:0] sq1_r, sq2_r;
  logic [63:0] w_sum;
  logic        in_circle;
  pair_t       push_word_r;

  // Align the draws to Q0.32 and take |2u - 1| in Q0.31.
  always_comb begin
    ua     = word.uniform_a << SHIFT;
    ub     = word.uniform_b << SHIFT;
    a1_nxt = ua[31] ? {1'b0, ua[30:0]} : (32'h8000_0000 - ua);
    a2_nxt = ub[31] ? {1'b0, ub[30:0]} : (32'h8000_0000 - ub);
  end

  // Stage one: magnitudes; stage two: squares.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= take;
      v2_r <= v1_r;
    end
    neg1_r <= ~ua[31];
    a1_r   <= a1_nxt;
    a2_r   <= a2_nxt;
    neg2_r <= neg1_r;
    sq1_r  <= a1_r * a1_r;
    sq2_r  <= a2_r * a2_r;
  end

  // Stage three: w and the unit circle test. Origin and outside are dropped.
  always_comb begin
    w_sum     = sq1_r + sq2_r;
    in_circle = (w_sum != 64'd0) && (w_sum[63:62] == 2'b00);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      push_valid_r <= 1'b0;
    end else begin
      push_valid_r <= v2_r && in_circle;
    end
    push_word_r.neg <= neg2_r;
    push_word_r.sq1 <= sq1_r[61:0];
    push_word_r.w   <= w_sum[61:0];
  end

  assign push_valid = push_valid_r;
  assign push_word  = push_word_r;

endmodule
`default_nettype wire

@@ hw/rtl/gpt_queue.sv @@
`default_nettype none
module gpt_queue import gpt_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_valid,
  input  wire pair_t push_word,
  output logic       pop_valid,
  output pair_t      pop_word,
  output logic       nearly_full
);

  pair_t                  mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_PTR_W:0]   count_r, count_nxt;
  logic                   pop;

  // The back part takes a word in every cycle that the queue holds one.
  assign pop         = (count_r != '0);
  assign pop_valid   = pop;
  assign pop_word    = mem[rd_ptr_r];
  assign nearly_full = (count_r >= (QUEUE_PTR_W+1)'(QUEUE_DEPTH - FRONT_STAGES));

  always_comb begin
    count_nxt = count_r;
    if (push_valid && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push_valid && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push_valid) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
    if (push_valid) begin
      mem[wr_ptr_r] <= push_word;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/gpt_solve.sv @@
`default_nettype none
module gpt_solve import gpt_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire pair_t in_pair,
  output logic       zsq_valid,
  output zsq_t       zsq
);

  // Stages 0..32 divide x1^2/w and take -log2(w) side by side, then
  // N, L = -2 ln w, the two partial products of L*r, and their sum.
  localparam int NS = 37;

  typedef struct packed {
    logic        neg;
    logic [61:0] w;
    logic [61:0] rem;
    logic [32:0] r;
    logic [1:0]  c;
    logic [5:0]  p;
    logic [30:0] m;
    logic [29:0] frac;
    logic [35:0] n;
    logic [36:0] l;
    logic [53:0] pph;
    logic [52:0] ppl;
    logic [37:0] t;
  } slv_t;

  slv_t src [NS];
  slv_t nxt [NS];
  slv_t st_r [NS];
  logic vld_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    if (k == 0) begin : g_in
      always_comb begin
        src[k]     = '0;
        src[k].neg = in_pair.neg;
        src[k].w   = in_pair.w;
        src[k].rem = in_pair.sq1;
      end
    end else begin : g_link
      always_comb begin
        src[k] = st_r[k-1];
      end
    end

    // Work of one stage.
    always_comb begin
      slv_t        s;
      logic [62:0] rem2;
      logic [63:0] wx;
      logic [15:0] seg;
      logic [3:0]  loc;
      logic [61:0] sq;
      logic [31:0] tt;
      logic [63:0] lp;
      logic [69:0] acc;
      s    = src[k];
      rem2 = '0;
      wx   = {2'b00, s.w};
      seg  = '0;
      loc  = '0;
      sq   = '0;
      tt   = '0;
      lp   = '0;
      acc  = '0;
      // Restoring division, one quotient bit a stage.
      if (k == 0) begin
        if (s.rem >= s.w) begin
          s.rem = s.rem - s.w;
          s.r   = 33'd1;
        end
      end else if (k <= 32) begin
        rem2 = {s.rem, 1'b0};
        s.r  = {s.r[31:0], 1'b0};
        if (rem2 >= {1'b0, s.w}) begin
          rem2   = rem2 - {1'b0, s.w};
          s.r[0] = 1'b1;
        end
        s.rem = rem2[61:0];
      end
      // Logarithm: leading one search, normalize, then squaring rounds.
      if (k == 0) begin
        if (wx[63:48] != '0) begin
          s.c = 2'd3;
        end else if (wx[47:32] != '0) begin
          s.c = 2'd2;
        end else if (wx[31:16] != '0) begin
          s.c = 2'd1;
        end else begin
          s.c = 2'd0;
        end
      end else if (k == 1) begin
        seg = wx[{s.c, 4'b0000} +: 16];
        for (int i = 0; i < 16; i++) begin
          if (seg[i]) begin
            loc = 4'(i);
          end
        end
        s.p = {s.c, loc};
      end else if (k == 2) begin
        if (s.p >= 6'd30) begin
          s.m = 31'(s.w >> (s.p - 6'd30));
        end else begin
          s.m = 31'(s.w << (6'd30 - s.p));
        end
      end else if (k <= 32) begin
        sq = s.m * s.m;
        tt = sq[61:30];
        if (tt[31]) begin
          s.m    = tt[31:1];
          s.frac = {s.frac[28:0], 1'b1};
        end else begin
          s.m    = tt[30:0];
          s.frac = {s.frac[28:0], 1'b0};
        end
      end else if (k == 33) begin
        s.n = {6'd62 - s.p, 30'b0} - {6'b0, s.frac};
      end else if (k == 34) begin
        lp  = s.n * LN2X2_Q27;
        s.l = lp[63:27];
      end else if (k == 35) begin
        s.pph = s.l * s.r[32:16];
        s.ppl = s.l * s.r[15:0];
      end else begin
        acc = {s.pph, 16'b0} + {17'b0, s.ppl};
        s.t = acc[69:32];
      end
      nxt[k] = s;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= (k == 0) ? in_valid : vld_r[(k == 0) ? 0 : k-1];
      end
      st_r[k] <= nxt[k];
    end
  end

  assign zsq_valid = vld_r[NS-1];
  assign zsq.neg   = st_r[NS-1].neg;
  assign zsq.t     = st_r[NS-1].t;

endmodule
`default_nettype wire

@@ hw/rtl/gpt_root.sv @@
`default_nettype none
module gpt_root import gpt_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               zsq_valid,
  input  wire zsq_t               zsq,
  input  wire logic signed [31:0] mean,
  input  wire logic        [31:0] sigma,
  output logic                    res_valid,
  output out_word_t               res_word
);

  // Stages 0..30 take the square root two bits of radicand a stage,
  // stage 31 forms sigma*|z|.
  localparam int NR = 32;

  typedef struct packed {
    logic        neg;
    logic [61:0] v;
    logic [61:0] res;
    logic [35:0] prod;
  } rt_t;

  rt_t  src [NR];
  rt_t  nxt [NR];
  rt_t  st_r [NR];
  logic vld_r [NR];
  logic      out_valid_r;
  out_word_t out_word_r;
  logic [37:0] sum;
  logic [30:0] zmag;

  for (genvar k = 0; k < NR; k++) begin : g_stage
    if (k == 0) begin : g_in
      always_comb begin
        src[k]     = '0;
        src[k].neg = zsq.neg;
        src[k].v   = {zsq.t, 24'b0};
      end
    end else begin : g_link
      always_comb begin
        src[k] = st_r[k-1];
      end
    end

    always_comb begin
      rt_t         s;
      logic [61:0] trial;
      logic [62:0] pr;
      s     = src[k];
      trial = '0;
      pr    = '0;
      if (k < NR - 1) begin
        trial = s.res + (62'd1 << (60 - 2*k));
        if (s.v >= trial) begin
          s.v   = s.v - trial;
          s.res = (s.res >> 1) + (62'd1 << (60 - 2*k));
        end else begin
          s.res = s.res >> 1;
        end
      end else begin
        pr     = sigma * s.res[30:0];
        s.prod = pr[62:27];
      end
      nxt[k] = s;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= (k == 0) ? zsq_valid : vld_r[(k == 0) ? 0 : k-1];
      end
      st_r[k] <= nxt[k];
    end
  end

  // Signed result and mean plus scaled sample with saturation.
  always_comb begin
    zmag = st_r[NR-1].res[30:0];
    if (st_r[NR-1].neg) begin
      sum = {{6{mean[31]}}, mean} - {2'b00, st_r[NR-1].prod};
    end else begin
      sum = {{6{mean[31]}}, mean} + {2'b00, st_r[NR-1].prod};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[NR-1];
    end
    if (st_r[NR-1].neg) begin
      out_word_r.unit_normal <= 32'(~{1'b0, zmag} + 32'd1);
    end else begin
      out_word_r.unit_normal <= {1'b0, zmag};
    end
    if (sum[37:31] == 7'h00 || sum[37:31] == 7'h7F) begin
      out_word_r.scaled_sample <= sum[31:0];
    end else if (sum[37]) begin
      out_word_r.scaled_sample <= 32'h8000_0000;
    end else begin
      out_word_r.scaled_sample <= 32'h7FFF_FFFF;
    end
  end

  assign res_valid = out_valid_r;
  assign res_word  = out_word_r;

endmodule
`default_nettype wire

@@ hw/rtl/gaussian_polar_transform_top.sv @@
// Marsaglia polar transform. Each accepted pair of uniform draws gives either
// one result word or nothing: pairs outside the unit circle and the pair at
// the origin are dropped. The block takes one pair in every clock cycle in
// which start is high and busy is low. Each pair passes through the 33
// restoring division steps and 30 logarithm squaring rounds run side by
// side, then the 31 square root steps. Results come in input order on a one
// cycle strobe and the receiver cannot stall them. busy rises only when the
// queue between the front and the back part nears full. Configuration writes
// are always ready and should be made while no pair is in flight.
`default_nettype none
module gaussian_polar_transform_top import gpt_pkg::*; #(
  parameter int UNIFORM_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire in_word_t             in_word,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  output logic                      out_valid,
  output out_word_t                 out_word
);

  logic signed [31:0] mean_r, mean_nxt;
  logic        [31:0] sigma_r, sigma_nxt;
  logic  take;
  logic  push_valid, pop_valid, nearly_full, zsq_valid;
  pair_t push_word, pop_word;
  zsq_t  zsq;

  assign cfg_ready = 1'b1;
  assign busy      = nearly_full;
  assign take      = start && !busy;

  // Configuration registers; unknown indexes are ignored.
  always_comb begin
    mean_nxt  = mean_r;
    sigma_nxt = sigma_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_OFFSET_MEAN) begin
        mean_nxt = cfg_data;
      end else if (cfg_index == REG_SPREAD_SIGMA) begin
        sigma_nxt = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r  <= MEAN_RESET;
      sigma_r <= SIGMA_RESET;
    end else begin
      mean_r  <= mean_nxt;
      sigma_r <= sigma_nxt;
    end
  end

  gpt_front #(.UNIFORM_BITS(UNIFORM_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .word       (in_word),
    .push_valid (push_valid),
    .push_word  (push_word)
  );

  gpt_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_valid  (push_valid),
    .push_word   (push_word),
    .pop_valid   (pop_valid),
    .pop_word    (pop_word),
    .nearly_full (nearly_full)
  );

  gpt_solve u_solve (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pop_valid),
    .in_pair   (pop_word),
    .zsq_valid (zsq_valid),
    .zsq       (zsq)
  );

  gpt_root u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .zsq_valid (zsq_valid),
    .zsq       (zsq),
    .mean      (mean_r),
    .sigma     (sigma_r),
    .res_valid (out_valid),
    .res_word  (out_word)
  );

endmodule
`default_nettype wire
